>>> hw/rtl/aww_pkg.sv
package aww_pkg;

    // Field widths of the two streams and the configuration register
    localparam int SAMPLE_W  = 12;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int S_PAD_W   = S_TDATA_W - SAMPLE_W - COL_W;
    localparam int M_PAD_W   = M_TDATA_W - 2 * SAMPLE_W - ROW_W;

    // Reset values of the scaling state
    localparam logic [SAMPLE_W-1:0] LEAST_SPAN_RST = 12'd10;
    localparam logic [SAMPLE_W-1:0] SCALE_SPAN_RST = 12'd10;

    // Function codes carried on s_tuser
    typedef enum logic {
        FUNC_PUSH  = 1'b0,
        FUNC_QUERY = 1'b1
    } aww_func_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic write_push;
        logic scan_step;
        logic commit;
        logic query_read;
        logic query_mul;
        logic div_step;
        logic load_out;
    } aww_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic out_free;
    } aww_sts_t;

endpackage

>>> hw/rtl/aww_ram.sv
module aww_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/aww_ctrl.sv
module aww_ctrl
    import aww_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      s_tuser,
    input  aww_sts_t  sts,
    output aww_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_WRITE  = 8'b0000_0010,
        ST_SCAN   = 8'b0000_0100,
        ST_COMMIT = 8'b0000_1000,
        ST_QREAD  = 8'b0001_0000,
        ST_QMUL   = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } aww_state_t;

    aww_state_t state_reg, state_next;

    // Sequence one transaction through push or query steps
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = (s_tuser == FUNC_QUERY) ? ST_QREAD : ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write_push = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_COMMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_QREAD: begin
                cmd.query_read = 1'b1;
                state_next     = ST_QMUL;
            end
            ST_QMUL: begin
                cmd.query_mul = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // One transaction at a time: no second accept straight after the first
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    // A result is loaded only when the output register can take it
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (sts.out_free && state_reg == ST_OUT))
        else $error("result loaded over an unread result");

endmodule

>>> hw/rtl/aww_datapath.sv
module aww_datapath
    import aww_pkg::*;
#(
    parameter int WINDOW_LEN  = 128,
    parameter int PLOT_HEIGHT = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [SAMPLE_W-1:0]  cfg_wr_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  aww_cmd_t             cmd,
    output aww_sts_t             sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW  = $clog2(WINDOW_LEN);
    localparam int AX  = AW + 1;
    localparam int FW  = $clog2(WINDOW_LEN + 1);
    localparam int HW  = $clog2(PLOT_HEIGHT);
    localparam int PW  = SAMPLE_W + HW;
    localparam int DCW = $clog2(PW + 1);
    localparam int RW  = SAMPLE_W + 1;

    localparam logic [AX-1:0]  LEN_X    = AX'(WINDOW_LEN);
    localparam logic [AW-1:0]  LAST_X   = AW'(WINDOW_LEN - 1);
    localparam logic [FW-1:0]  FILL_MAX = FW'(WINDOW_LEN);
    localparam logic [HW-1:0]  H1       = HW'(PLOT_HEIGHT - 1);
    localparam logic [DCW-1:0] DIV_LEN  = DCW'(PW);

    // Captured transaction
    logic [SAMPLE_W-1:0] sample_reg;
    logic [COL_W-1:0]    col_reg;
    logic                query_reg;

    // Window bookkeeping and scaling state
    logic [AW-1:0]       oldest_reg, oldest_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [SAMPLE_W-1:0] low_mark_reg, low_mark_next;
    logic [SAMPLE_W-1:0] span_reg, span_next;
    logic [SAMPLE_W-1:0] least_reg, least_next;

    // Scan
    logic [AX-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                pend_reg, pend_next;
    logic                pend_ok_reg;
    logic [SAMPLE_W-1:0] lo_reg, hi_reg;

    // Query and divider
    logic                q_ok_reg;
    logic [RW-1:0]       rem_reg;
    logic [PW-1:0]       num_reg;
    logic [DCW-1:0]      div_cnt_reg, div_cnt_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;

    // Memory ports
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic [SAMPLE_W-1:0] floor_span;
    logic [SAMPLE_W-1:0] scan_val;
    logic [SAMPLE_W-1:0] diff;
    logic [AW-1:0]       col_sat;
    logic [AX-1:0]       idx_sum;
    logic [AW-1:0]       q_idx;
    logic [SAMPLE_W-1:0] q_val;
    logic [SAMPLE_W-1:0] off_raw;
    logic [SAMPLE_W-1:0] off_c;
    logic [PW-1:0]       prod;
    logic [RW-1:0]       rem_sh;
    logic                rem_ge;
    logic [HW-1:0]       row_full;
    logic [ROW_W-1:0]    row_out;

    aww_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (cmd.write_push),
        .wr_addr (oldest_reg),
        .wr_data (sample_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // A zero floor counts as one so the span never reaches zero
    assign floor_span = (least_reg == '0) ? SAMPLE_W'(1) : least_reg;

    // Ring position of the queried column; columns past the window take the newest
    assign col_sat = (32'(col_reg) >= 32'(WINDOW_LEN)) ? LAST_X : AW'(col_reg);
    assign idx_sum = {1'b0, oldest_reg} + {1'b0, col_sat};
    assign q_idx   = (idx_sum >= LEN_X) ? AW'(idx_sum - LEN_X) : idx_sum[AW-1:0];

    assign ram_raddr = cmd.query_read ? q_idx : scan_cnt_reg[AW-1:0];

    // Entries beyond the fill count were never written and read as zero
    assign scan_val = pend_ok_reg ? ram_rdata : '0;
    assign q_val    = q_ok_reg ? ram_rdata : '0;
    assign diff     = hi_reg - lo_reg;

    // Offset above the minimum, clamped to the span, times the top row
    assign off_raw = (q_val > low_mark_reg) ? (q_val - low_mark_reg) : '0;
    assign off_c   = (off_raw > span_reg) ? span_reg : off_raw;
    assign prod    = {{HW{1'b0}}, off_c} * {{SAMPLE_W{1'b0}}, H1};

    // Restoring divider step: one quotient bit per cycle
    assign rem_sh = {rem_reg[SAMPLE_W-1:0], num_reg[PW-1]};
    assign rem_ge = rem_sh >= {1'b0, span_reg};

    assign row_full = H1 - num_reg[HW-1:0];
    assign row_out  = query_reg ? ROW_W'(row_full) : '0;

    assign sts.scan_done = (scan_cnt_reg == LEN_X) && !pend_reg;
    assign sts.div_done  = (div_cnt_reg == '0);
    assign sts.out_free  = !m_valid_reg || m_tready;

    // Next values of the control state
    always_comb begin
        oldest_next   = oldest_reg;
        fill_next     = fill_reg;
        low_mark_next = low_mark_reg;
        span_next     = span_reg;
        least_next    = least_reg;
        scan_cnt_next = scan_cnt_reg;
        pend_next     = pend_reg;
        div_cnt_next  = div_cnt_reg;
        m_valid_next  = m_valid_reg;

        if (cfg_wr_en) begin
            least_next = cfg_wr_data;
        end
        // Advance the ring after the write, count the fill up to the window
        if (cmd.write_push) begin
            oldest_next   = (oldest_reg == LAST_X) ? '0 : oldest_reg + AW'(1);
            fill_next     = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + FW'(1);
            scan_cnt_next = '0;
            pend_next     = 1'b0;
        end
        if (cmd.scan_step) begin
            pend_next = (scan_cnt_reg != LEN_X);
            if (scan_cnt_reg != LEN_X) begin
                scan_cnt_next = scan_cnt_reg + AX'(1);
            end
        end
        if (cmd.commit) begin
            low_mark_next = lo_reg;
            span_next     = (diff > floor_span) ? diff : floor_span;
        end
        if (cmd.query_mul) begin
            div_cnt_next = DIV_LEN;
        end
        if (cmd.div_step) begin
            div_cnt_next = div_cnt_reg - DCW'(1);
        end
        // Hold the result until taken
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg   <= '0;
            fill_reg     <= '0;
            low_mark_reg <= '0;
            span_reg     <= SCALE_SPAN_RST;
            least_reg    <= LEAST_SPAN_RST;
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            div_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            oldest_reg   <= oldest_next;
            fill_reg     <= fill_next;
            low_mark_reg <= low_mark_next;
            span_reg     <= span_next;
            least_reg    <= least_next;
            scan_cnt_reg <= scan_cnt_next;
            pend_reg     <= pend_next;
            div_cnt_reg  <= div_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            col_reg    <= s_tdata[SAMPLE_W +: COL_W];
            query_reg  <= s_tuser;
        end
        // Start the scan from an empty range
        if (cmd.write_push) begin
            lo_reg <= '1;
            hi_reg <= '0;
        end
        if (cmd.scan_step) begin
            pend_ok_reg <= FW'(scan_cnt_reg[AW-1:0]) < fill_reg;
            if (pend_reg) begin
                if (scan_val < lo_reg) begin
                    lo_reg <= scan_val;
                end
                if (scan_val > hi_reg) begin
                    hi_reg <= scan_val;
                end
            end
        end
        if (cmd.query_read) begin
            q_ok_reg <= FW'(q_idx) < fill_reg;
        end
        if (cmd.query_mul) begin
            num_reg <= prod;
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_ge ? (rem_sh - {1'b0, span_reg}) : rem_sh;
            num_reg <= {num_reg[PW-2:0], rem_ge};
        end
        if (cmd.load_out) begin
            m_data_reg <= {{M_PAD_W{1'b0}}, row_out, span_reg, low_mark_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_span_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        span_reg != '0)
        else $error("scale span reached zero");

    a_commit_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> span_reg >= $past(floor_span))
        else $error("committed span below the floor");

    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && query_reg) |-> num_reg <= PW'(PLOT_HEIGHT - 1))
        else $error("row quotient beyond the plot height");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill count beyond the window length");

endmodule

>>> hw/rtl/autorange_waveform_window.sv
// Channel   Direction  Ports                        Contents
// s_        in         s_tvalid s_tready            s_tdata: sample, column; s_tuser: func
// m_        out        m_tvalid m_tready            m_tdata: window_min, window_span, plot_row
// cfg_      in         cfg_wr_en cfg_wr_data        least_span, written at any enabled edge
//
// A push writes the sample into the window memory, then reads the memory one entry per
// cycle for the min/max scan and commits the new minimum and span. A query reads its
// column, multiplies, then runs the bit-serial divider (one quotient bit per cycle).
// One transaction is in progress at a time; the next is accepted while the result
// waits in the output register. A stalled m_ side holds the result and the block.
// Reset is synchronous, active low; the window reads as zeros until each entry is
// written, tracked by a fill count, so no clearing pass follows reset.
module autorange_waveform_window
    import aww_pkg::*;
#(
    parameter int WINDOW_LEN  = 128,
    parameter int PLOT_HEIGHT = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [SAMPLE_W-1:0]  cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] sample, [18:12] column
    input  logic                 s_tuser,   // [0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [11:0] window_min, [23:12] window_span,
                                            // [28:24] plot_row
);

    aww_cmd_t cmd;
    aww_sts_t sts;

    aww_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    aww_datapath #(
        .WINDOW_LEN  (WINDOW_LEN),
        .PLOT_HEIGHT (PLOT_HEIGHT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb
    import aww_pkg::*;
();

    localparam int WINDOW_LEN     = 128;
    localparam int PLOT_HEIGHT    = 32;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 153;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 200;

    typedef struct {
        logic [SAMPLE_W-1:0] window_min;
        logic [SAMPLE_W-1:0] window_span;
        logic [ROW_W-1:0]    plot_row;
    } trace_result_t;

    // Shadow of the window and scaling state, plus the queue of expected results
    class autorange_scoreboard;
        logic [SAMPLE_W-1:0] samples [WINDOW_LEN];
        int unsigned         oldest;
        logic [SAMPLE_W-1:0] low_mark;
        logic [SAMPLE_W-1:0] scale_span;
        logic [SAMPLE_W-1:0] least_span;
        trace_result_t       pending [$];
        int unsigned         errors;
        int unsigned         pushes;
        int unsigned         queries;
        int unsigned         checked;

        function new();
            foreach (samples[i]) samples[i] = '0;
            oldest     = 0;
            low_mark   = '0;
            scale_span = SCALE_SPAN_RST;
            least_span = LEAST_SPAN_RST;
            errors     = 0;
            pushes     = 0;
            queries    = 0;
            checked    = 0;
        endfunction

        function void set_least_span(logic [SAMPLE_W-1:0] value);
            least_span = value;
        endfunction

        // Recompute the minimum and the span over the whole window
        function void rescan();
            logic [SAMPLE_W-1:0] lo;
            logic [SAMPLE_W-1:0] hi;
            int unsigned         floor_span;
            int unsigned         diff;
            lo = samples[0];
            hi = samples[0];
            foreach (samples[i]) begin
                if (samples[i] < lo) lo = samples[i];
                if (samples[i] > hi) hi = samples[i];
            end
            // a zero floor behaves as one, so the span never vanishes
            floor_span = (least_span == 0) ? 1 : least_span;
            diff       = hi - lo;
            low_mark   = lo;
            scale_span = SAMPLE_W'((diff > floor_span) ? diff : floor_span);
        endfunction

        // Update the shadow state for an accepted transaction and queue its result
        function void note_item(aww_func_t func, logic [SAMPLE_W-1:0] value,
                                logic [COL_W-1:0] column);
            trace_result_t want;
            int unsigned   v;
            int unsigned   off;
            int unsigned   span;
            want.plot_row = '0;
            if (func == FUNC_PUSH) begin
                samples[oldest] = value;
                oldest          = (oldest + 1) % WINDOW_LEN;
                rescan();
                pushes++;
            end else begin
                span = (scale_span == 0) ? 1 : scale_span;
                v    = samples[(oldest + column) % WINDOW_LEN];
                off  = (v > low_mark) ? v - low_mark : 0;
                if (off > span) off = span;
                want.plot_row = ROW_W'((PLOT_HEIGHT - 1) - off * (PLOT_HEIGHT - 1) / span);
                queries++;
            end
            want.window_min  = low_mark;
            want.window_span = scale_span;
            pending.push_back(want);
        endfunction

        function void report_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare an accepted result with the oldest expectation
        function void check_result(logic [M_TDATA_W-1:0] data);
            trace_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got 0x%08h",
                         $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            report_field("window_min", want.window_min, data[11:0]);
            report_field("window_span", want.window_span, data[23:12]);
            report_field("plot_row", want.plot_row, data[28:24]);
        endfunction
    endclass

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [SAMPLE_W-1:0]  cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;

    logic                 steady      = 1'b0;
    int unsigned          settings    = 0;
    int unsigned          quiet_cycles;

    autorange_scoreboard sb = new();

    autorange_waveform_window #(
        .WINDOW_LEN  (WINDOW_LEN),
        .PLOT_HEIGHT (PLOT_HEIGHT)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Stall the result side now and then, except in the steady stretch
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 10);
    end

    // Track register writes, accepted inputs and accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) sb.set_least_span(cfg_wr_data);
            if (s_tvalid && s_tready)
                sb.note_item(aww_func_t'(s_tuser), s_tdata[11:0], s_tdata[18:12]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // End the run when no transaction moves for too long
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Offer one item, with an occasional gap before it; return once it is taken
    task automatic send_item(input aww_func_t func, input logic [SAMPLE_W-1:0] value,
                             input logic [COL_W-1:0] column);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{S_PAD_W{1'b0}}, column, value};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the input side until every expected result has been taken
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
    endtask

    // Called at a falling edge with the block idle
    task automatic write_least_span(input logic [SAMPLE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] value;
        logic [SAMPLE_W-1:0] floor_setting;
        int unsigned         spread;
        int unsigned         push_pct;
        bit                  banded;
        aww_func_t           func;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Freshly reset window reads as zeros with the reset span
        send_item(FUNC_QUERY, 12'd0, 7'd0);
        send_item(FUNC_QUERY, 12'd0, 7'd127);

        // Zero floor on a flat window gives a span of one
        wait_drained();
        write_least_span(12'd0);
        send_item(FUNC_PUSH, 12'd0, 7'd0);
        send_item(FUNC_QUERY, 12'd0, 7'd64);

        // Small excursion is stretched to the floor
        wait_drained();
        write_least_span(12'd10);
        send_item(FUNC_PUSH, 12'd5, 7'd0);
        send_item(FUNC_PUSH, 12'd7, 7'd0);
        send_item(FUNC_QUERY, 12'd0, 7'd127);

        // Raised floor only takes effect at the next push
        wait_drained();
        write_least_span(12'd4095);
        send_item(FUNC_QUERY, 12'd4095, 7'd127);
        send_item(FUNC_PUSH, 12'd3, 7'd0);
        send_item(FUNC_QUERY, 12'd0, 7'd127);

        // Full-scale swing and mid-scale rounding
        wait_drained();
        write_least_span(12'd1);
        send_item(FUNC_PUSH, 12'd4095, 7'd127);
        send_item(FUNC_PUSH, 12'd0, 7'd127);
        send_item(FUNC_QUERY, 12'd0, 7'd127);
        send_item(FUNC_QUERY, 12'd0, 7'd126);
        send_item(FUNC_PUSH, 12'd2048, 7'd0);
        send_item(FUNC_QUERY, 12'd4095, 7'd127);
        send_item(FUNC_PUSH, 12'd4094, 7'd0);
        send_item(FUNC_QUERY, 12'd0, 7'd125);
        send_item(FUNC_QUERY, 12'd0, 7'd0);

        // Random phases: full-range traces alternate with narrow, near-flat bands
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase % 5)
                0:       floor_setting = 12'd4095;
                1:       floor_setting = 12'd0;
                2:       floor_setting = 12'd1;
                3:       floor_setting = SAMPLE_W'($urandom_range(4094, 2));
                default: floor_setting = SAMPLE_W'($urandom_range(63, 0));
            endcase
            write_least_span(floor_setting);
            steady   = (phase == 4);
            banded   = phase[0];
            push_pct = banded ? 90 : 60;
            base     = SAMPLE_W'($urandom_range(4095 - 15, 0));
            spread   = $urandom_range(15, 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                func = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_QUERY;
                if (banded)
                    value = SAMPLE_W'(base + $urandom_range(spread, 0));
                else if ($urandom_range(99) < 5)
                    value = $urandom_range(1, 0) ? 12'd4095 : 12'd0;
                else
                    value = SAMPLE_W'($urandom_range(4095, 0));
                send_item(func, value, COL_W'($urandom_range(127, 0)));
            end
        end
        steady = 1'b0;

        // Let any stray result surface before closing
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d results still expected, none arrived", $time,
                     sb.pending.size());
            sb.errors++;
        end

        $display("Covered %0d pushes and %0d column queries under %0d least-span settings,",
                 sb.pushes, sb.queries, settings);
        $display("including zero and full-scale floors, flat bands and full-range traces.");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
